/* rtl/core/avccrp_pkg.sv */
package avccrp_pkg;

  // role of a record byte, as reported in field_kind
  typedef logic [3:0] field_kind_t;

  localparam field_kind_t KIND_VERSION  = 4'd0;
  localparam field_kind_t KIND_PROFILE  = 4'd1;
  localparam field_kind_t KIND_COMPAT   = 4'd2;
  localparam field_kind_t KIND_LEVEL    = 4'd3;
  localparam field_kind_t KIND_LENSIZE  = 4'd4;
  localparam field_kind_t KIND_SPSCOUNT = 4'd5;
  localparam field_kind_t KIND_SPSHI    = 4'd6;
  localparam field_kind_t KIND_SPSLO    = 4'd7;
  localparam field_kind_t KIND_SPSDATA  = 4'd8;
  localparam field_kind_t KIND_PPSCOUNT = 4'd9;
  localparam field_kind_t KIND_PPSHI    = 4'd10;
  localparam field_kind_t KIND_PPSLO    = 4'd11;
  localparam field_kind_t KIND_PPSDATA  = 4'd12;
  localparam field_kind_t KIND_TRAILER  = 4'd13;

  typedef logic [1:0] record_status_t;

  localparam record_status_t STATUS_CONTINUES = 2'd0;
  localparam record_status_t STATUS_COMPLETE  = 2'd1;
  localparam record_status_t STATUS_TRUNCATED = 2'd2;

  localparam logic [7:0] LENSIZE_MASK  = 8'h03;
  localparam logic [7:0] SPSCOUNT_MASK = 8'h0f;
  localparam logic [7:0] PPSCOUNT_MASK = 8'hff;

endpackage

/* rtl/core/avccrp_in_if.sv */
interface avccrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* rtl/core/avccrp_out_if.sv */
interface avccrp_out_if
  import avccrp_pkg::*;
;
  logic           valid;
  logic           ready;
  field_kind_t    field_kind;
  logic [15:0]    field_value;
  logic [7:0]     entry_index;
  logic           entry_end;
  record_status_t record_status;

  modport source (
    output valid, output field_kind, output field_value, output entry_index,
    output entry_end, output record_status, input ready
  );
  modport sink (
    input valid, input field_kind, input field_value, input entry_index,
    input entry_end, input record_status, output ready
  );
endinterface

/* rtl/core/avc_config_record_parser_unit.sv */
// each accepted record byte is registered and shows as its tagged result beat in the next cycle
// throughput: one byte per cycle; a byte is taken whenever the result register
//   is empty or its beat is being taken in the same cycle
// reset: rst is synchronous, active high; the parser returns to the version
//   byte with all counters cleared and the result register empty
module avc_config_record_parser_unit
  import avccrp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  avccrp_in_if.sink           byte_stream,
  avccrp_out_if.source        field_stream
);

  // expected role of the next byte; codes match field_kind
  typedef enum logic [3:0] {
    PH_VERSION  = 4'd0,
    PH_PROFILE  = 4'd1,
    PH_COMPAT   = 4'd2,
    PH_LEVEL    = 4'd3,
    PH_LENSIZE  = 4'd4,
    PH_SPSCOUNT = 4'd5,
    PH_SPSHI    = 4'd6,
    PH_SPSLO    = 4'd7,
    PH_SPSDATA  = 4'd8,
    PH_PPSCOUNT = 4'd9,
    PH_PPSHI    = 4'd10,
    PH_PPSLO    = 4'd11,
    PH_PPSDATA  = 4'd12,
    PH_TRAILER  = 4'd13
  } phase_t;

  // parser state
  phase_t      phase;
  logic [7:0]  entries_left;
  logic [15:0] payload_left;
  logic [7:0]  size_high;
  logic [7:0]  entry_counter;

  // result register
  logic           out_valid;
  field_kind_t    out_kind;
  logic [15:0]    out_value;
  logic [7:0]     out_index;
  logic           out_end;
  record_status_t out_status;

  // combinational next values
  phase_t         phase_next;
  logic [7:0]     entries_left_next;
  logic [15:0]    payload_left_next;
  logic [7:0]     size_high_next;
  logic [7:0]     entry_counter_next;
  logic [15:0]    value_next;
  logic [7:0]     index_next;
  logic           end_next;
  record_status_t status_next;

  logic        accept;
  logic [7:0]  b;
  logic [15:0] entry_size;
  logic [15:0] payload_dec;
  logic [7:0]  entries_dec;
  logic [7:0]  count_sps;

  // the input side moves whenever the result slot frees up in this cycle
  assign byte_stream.ready = !out_valid || field_stream.ready;
  assign accept            = byte_stream.valid && byte_stream.ready;

  assign b           = byte_stream.data_byte;
  assign entry_size  = {size_high, b};
  assign payload_dec = payload_left - 16'd1;
  assign entries_dec = entries_left - 8'd1;
  assign count_sps   = b & SPSCOUNT_MASK;

  always_comb begin
    phase_next         = phase;
    entries_left_next  = entries_left;
    payload_left_next  = payload_left;
    size_high_next     = size_high;
    entry_counter_next = entry_counter;
    value_next         = {8'h00, b};
    index_next         = 8'h00;
    end_next           = 1'b0;
    status_next        = STATUS_CONTINUES;

    case (phase)
      PH_VERSION: phase_next = PH_PROFILE;
      PH_PROFILE: phase_next = PH_COMPAT;
      PH_COMPAT:  phase_next = PH_LEVEL;
      PH_LEVEL:   phase_next = PH_LENSIZE;
      PH_LENSIZE: begin
        // nal length size is coded minus one in the low two bits
        value_next = {8'h00, (b & LENSIZE_MASK) + 8'd1};
        phase_next = PH_SPSCOUNT;
      end
      PH_SPSCOUNT: begin
        value_next         = {8'h00, count_sps};
        entries_left_next  = count_sps;
        entry_counter_next = 8'h00;
        // an empty sps list goes straight on to the pps count
        phase_next         = (count_sps != 8'h00) ? PH_SPSHI : PH_PPSCOUNT;
      end
      PH_PPSCOUNT: begin
        value_next         = {8'h00, b & PPSCOUNT_MASK};
        entries_left_next  = b & PPSCOUNT_MASK;
        entry_counter_next = 8'h00;
        phase_next         = ((b & PPSCOUNT_MASK) != 8'h00) ? PH_PPSHI : PH_TRAILER;
      end
      PH_SPSHI, PH_PPSHI: begin
        index_next     = entry_counter;
        size_high_next = b;
        phase_next     = (phase == PH_SPSHI) ? PH_SPSLO : PH_PPSLO;
      end
      PH_SPSLO, PH_PPSLO: begin
        index_next        = entry_counter;
        value_next        = entry_size;
        payload_left_next = entry_size;
        if (entry_size == 16'h0000) begin
          // a zero-size entry ends at its size byte
          end_next           = 1'b1;
          entries_left_next  = entries_dec;
          entry_counter_next = entry_counter + 8'd1;
          if (phase == PH_SPSLO) begin
            phase_next = (entries_dec == 8'h00) ? PH_PPSCOUNT : PH_SPSHI;
          end else begin
            phase_next = (entries_dec == 8'h00) ? PH_TRAILER : PH_PPSHI;
          end
        end else begin
          phase_next = (phase == PH_SPSLO) ? PH_SPSDATA : PH_PPSDATA;
        end
      end
      PH_SPSDATA, PH_PPSDATA: begin
        index_next        = entry_counter;
        payload_left_next = payload_dec;
        if (payload_dec == 16'h0000) begin
          end_next           = 1'b1;
          entries_left_next  = entries_dec;
          entry_counter_next = entry_counter + 8'd1;
          if (phase == PH_SPSDATA) begin
            phase_next = (entries_dec == 8'h00) ? PH_PPSCOUNT : PH_SPSHI;
          end else begin
            phase_next = (entries_dec == 8'h00) ? PH_TRAILER : PH_PPSHI;
          end
        end
      end
      default: phase_next = PH_TRAILER;
    endcase

    // last byte: report and start a fresh record
    if (byte_stream.last_byte) begin
      status_next        = (phase_next == PH_TRAILER) ? STATUS_COMPLETE : STATUS_TRUNCATED;
      phase_next         = PH_VERSION;
      entries_left_next  = 8'h00;
      payload_left_next  = 16'h0000;
      size_high_next     = 8'h00;
      entry_counter_next = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_VERSION;
      entries_left  <= 8'h00;
      payload_left  <= 16'h0000;
      size_high     <= 8'h00;
      entry_counter <= 8'h00;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        entries_left  <= entries_left_next;
        payload_left  <= payload_left_next;
        size_high     <= size_high_next;
        entry_counter <= entry_counter_next;
        out_kind      <= field_kind_t'(phase);
        out_value     <= value_next;
        out_index     <= index_next;
        out_end       <= end_next;
        out_status    <= status_next;
      end
      // result slot fills on a byte, empties on a taken beat
      if (accept) begin
        out_valid <= 1'b1;
      end else if (field_stream.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign field_stream.valid         = out_valid;
  assign field_stream.field_kind    = out_kind;
  assign field_stream.field_value   = out_value;
  assign field_stream.entry_index   = out_index;
  assign field_stream.entry_end     = out_end;
  assign field_stream.record_status = out_status;

  // an entry can only end on a size low byte or a payload byte
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_end |->
      (out_kind == KIND_SPSLO) || (out_kind == KIND_SPSDATA) ||
      (out_kind == KIND_PPSLO) || (out_kind == KIND_PPSDATA))
    else $error("entry end on a byte outside an entry");

  // inside a list there is always an entry still open
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SPSHI) || (phase == PH_SPSLO) || (phase == PH_SPSDATA) ||
    (phase == PH_PPSHI) || (phase == PH_PPSLO) || (phase == PH_PPSDATA) |->
      entries_left != 8'h00)
    else $error("list phase with no entries left");

  // payload phases always have bytes outstanding
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SPSDATA) || (phase == PH_PPSDATA) |-> payload_left != 16'h0000)
    else $error("payload phase with nothing left");

  // a last byte restarts the parser at the version byte
  assert property (@(posedge clk) disable iff (rst)
    accept && byte_stream.last_byte |=>
      (phase == PH_VERSION) && (entries_left == 8'h00) && (entry_counter == 8'h00))
    else $error("parser did not restart after last byte");

  // status is reported exactly when the byte was the last one
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (out_status != STATUS_CONTINUES) == $past(byte_stream.last_byte))
    else $error("record status does not match last byte mark");

endmodule
